// ----- design/fpq_pkg.sv -----
// ----------------------------------------------------------------------------
// fpq_pkg: shared types and constants of the frame presentation queue
// Holds the stored descriptor layout, action codes and register defaults.
// ----------------------------------------------------------------------------
package fpq_pkg;

  localparam int TIME_W = 48;
  localparam int EXT_W  = 50;
  localparam int MFT_W  = 17;
  localparam logic [MFT_W-1:0] MFT_RESET = 17'd375;

  localparam logic [2:0] ACT_PUSH        = 3'd0;
  localparam logic [2:0] ACT_TAKE_NEWEST = 3'd1;
  localparam logic [2:0] ACT_TAKE_BEST   = 3'd2;
  localparam logic [2:0] ACT_HAS_GEN     = 3'd3;
  localparam logic [2:0] ACT_HAS_KEY     = 3'd4;
  localparam logic [2:0] ACT_FLUSH       = 3'd5;

  typedef struct packed {
    logic [31:0]              key;
    logic [31:0]              gen;
    logic signed [TIME_W-1:0] tm;
    logic [31:0]              seq;
    logic [15:0]              handle;
    logic                     fallback;
    logic                     native;
  } entry_t;

endpackage

// ----- design/frame_presentation_queue_core.sv -----
// ----------------------------------------------------------------------------
// frame_presentation_queue_core: queue of decoded-frame descriptors
// Insertion-ordered table in one RAM, scanned and compacted by a sequencer.
// ----------------------------------------------------------------------------
//
//  channel  | ports                       | handshake
//  ---------+-----------------------------+------------------------------------
//  input    | in_*                        | taken when start high and busy low
//  result   | out_*                       | out_valid one cycle, cannot stall
//  config   | psel/penable/pwrite/paddr.. | APB, pready tied high
//
//  Sequence: a push or query scans the N live entries, one RAM read a cycle,
//  then wraps up; push adds a write. A full push or a successful best-frame
//  pop adds a compaction pass; the newest-frame pop reads one entry; flush
//  ends in the accept cycle. Reset clears the count, not the RAM. The
//  registered strobe lets the next item start in the result cycle; the
//  receiver cannot stall, so nothing ever waits on it.
// ----------------------------------------------------------------------------
module frame_presentation_queue_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     start,
  output logic                                     busy,
  input  logic [2:0]                               in_action,
  input  logic [31:0]                              in_frame_key,
  input  logic [31:0]                              in_generation,
  input  logic signed [47:0]                       in_frame_time,
  input  logic                                     in_native_buffer,
  input  logic                                     in_cpu_fallback,
  input  logic [31:0]                              in_sequence_req,
  input  logic [15:0]                              in_handle,
  input  logic signed [47:0]                       in_target_time,
  input  logic [31:0]                              in_frame_duration,
  output logic                                     out_valid,
  output logic                                     out_success,
  output logic [15:0]                              out_handle,
  output logic signed [47:0]                       out_time,
  output logic [31:0]                              out_key,
  output logic [31:0]                              out_generation,
  output logic [31:0]                              out_sequence,
  output logic                                     out_native,
  output logic                                     out_fallback,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]         out_occupancy,
  input  logic                                     psel,
  input  logic                                     penable,
  input  logic                                     pwrite,
  input  logic [1:0]                               paddr,
  input  logic [31:0]                              pwdata,
  output logic [31:0]                              prdata,
  output logic                                     pready
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = $bits(fpq_pkg::entry_t);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WRITE} state_t;
  typedef enum logic [1:0] {M_FIND, M_PURGE, M_REMOVE} mode_t;

  state_t state_r;
  mode_t  mode_r;

  logic [CW-1:0]               cnt_r, rp_r, wp_r, end_r;
  logic                        rv_r;
  logic [AW-1:0]               ra_r, rm_r, wr_addr_r;
  logic [2:0]                  act_r;
  fpq_pkg::entry_t             item_r, last_r, sel_r, b1e_r, b2e_r, oent_r;
  logic signed [fpq_pkg::EXT_W-1:0] target_r, cutoff_r, limit_r, b1v_r, b2d_r;
  logic [31:0]                 fd_r, b1s_r, b2s_r;
  logic [fpq_pkg::MFT_W-1:0]   mft_r;
  logic                        kfound_r, ofound_r, gfound_r, any_r, b1f_r, b2f_r;
  logic [AW-1:0]               kidx_r, oidx_r, b1i_r, b2i_r;
  logic [1:0]                  kflags_r;
  logic                        ov_r, osucc_r;

  // RAM ports
  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  fpq_pkg::entry_t             ram_wdata, ram_rdata;

  // Setup arithmetic for the best-frame pop
  logic [31:0]                 fd_c;
  logic signed [fpq_pkg::EXT_W-1:0] tgt_c, cutoff_c, limit_c;

  // Per-entry evaluation
  fpq_pkg::entry_t             e;
  logic signed [fpq_pkg::EXT_W-1:0] t_e, d_e;
  logic                        gen_eq, stale, keep_purge, keep_rm;
  logic                        cand1, beat1, cand2, beat2, rep;

  assign fd_c     = (in_frame_duration > {15'd0, mft_r}) ? in_frame_duration
                                                         : {15'd0, mft_r};
  assign tgt_c    = {{2{in_target_time[47]}}, in_target_time};
  assign cutoff_c = tgt_c - $signed({17'd0, fd_c, 1'b0});
  assign limit_c  = tgt_c + $signed({19'd0, fd_c[31:1]});

  assign e          = ram_rdata;
  assign t_e        = {{2{e.tm[47]}}, e.tm};
  assign d_e        = t_e - target_r;
  assign gen_eq     = (e.gen == item_r.gen);
  assign stale      = (e.gen < item_r.gen) || (gen_eq && (t_e < cutoff_r));
  assign keep_purge = !stale;
  assign keep_rm    = (ra_r != rm_r);
  assign cand1      = gen_eq && (t_e <= limit_r);
  assign beat1      = !b1f_r || (t_e > b1v_r) || ((t_e == b1v_r) && (e.seq > b1s_r));
  assign cand2      = gen_eq && !d_e[fpq_pkg::EXT_W-1] &&
                      (d_e <= $signed({18'd0, fd_r}));
  assign beat2      = !b2f_r || (d_e < b2d_r) || ((d_e == b2d_r) && (e.seq > b2s_r));

  // Replace a duplicate only when the new frame improves on it
  always_comb begin
    if (item_r.native != kflags_r[0]) begin
      rep = item_r.native;
    end else if (item_r.fallback != kflags_r[1]) begin
      rep = !item_r.fallback;
    end else begin
      rep = 1'b0;
    end
  end

  assign ram_re    = (state_r == S_SCAN) && (rp_r < end_r);
  assign ram_raddr = rp_r[AW-1:0];
  assign ram_we    = (state_r == S_WRITE) ||
                     ((state_r == S_SCAN) && rv_r &&
                      (((mode_r == M_PURGE) && keep_purge) ||
                       ((mode_r == M_REMOVE) && keep_rm)));
  assign ram_waddr = (state_r == S_WRITE) ? wr_addr_r : wp_r[AW-1:0];
  assign ram_wdata = (state_r == S_WRITE) ? item_r : e;

  fpq_ram #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      mode_r   <= M_FIND;
      cnt_r    <= '0;
      rv_r     <= 1'b0;
      ov_r     <= 1'b0;
      mft_r    <= fpq_pkg::MFT_RESET;
    end else begin
      ov_r <= 1'b0;
      if (psel && penable && pwrite) begin
        mft_r <= pwdata[fpq_pkg::MFT_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            item_r   <= '{key: in_frame_key, gen: in_generation, tm: in_frame_time,
                          seq: in_sequence_req, handle: in_handle,
                          fallback: in_cpu_fallback, native: in_native_buffer};
            act_r    <= in_action;
            target_r <= tgt_c;
            fd_r     <= fd_c;
            cutoff_r <= cutoff_c;
            limit_r  <= limit_c;
            kfound_r <= 1'b0;
            ofound_r <= 1'b0;
            gfound_r <= 1'b0;
            any_r    <= 1'b0;
            b1f_r    <= 1'b0;
            b2f_r    <= 1'b0;
            mode_r   <= M_FIND;
            rp_r     <= '0;
            wp_r     <= '0;
            end_r    <= cnt_r;
            rv_r     <= 1'b0;
            case (in_action) inside
              fpq_pkg::ACT_PUSH, fpq_pkg::ACT_HAS_GEN, fpq_pkg::ACT_HAS_KEY: begin
                state_r <= S_SCAN;
              end
              fpq_pkg::ACT_TAKE_NEWEST: begin
                // read only the newest entry
                rp_r    <= (cnt_r == '0) ? '0 : cnt_r - CW'(1);
                state_r <= S_SCAN;
              end
              fpq_pkg::ACT_TAKE_BEST: begin
                mode_r  <= M_PURGE;
                state_r <= S_SCAN;
              end
              fpq_pkg::ACT_FLUSH: begin
                cnt_r   <= '0;
                ov_r    <= 1'b1;
                osucc_r <= 1'b1;
                oent_r  <= '0;
              end
              default: begin
                ov_r    <= 1'b1;
                osucc_r <= 1'b0;
                oent_r  <= '0;
              end
            endcase
          end
        end

        S_SCAN: begin
          if (ram_re) begin
            rp_r <= rp_r + CW'(1);
          end
          rv_r <= ram_re;
          ra_r <= rp_r[AW-1:0];
          if (rv_r) begin
            case (mode_r)
              M_FIND: begin
                any_r  <= 1'b1;
                last_r <= e;
                if ((e.key == item_r.key) && !kfound_r) begin
                  kfound_r <= 1'b1;
                  kidx_r   <= ra_r;
                  kflags_r <= {e.fallback, e.native};
                end
                if ((e.gen < item_r.gen) && !ofound_r) begin
                  ofound_r <= 1'b1;
                  oidx_r   <= ra_r;
                end
                if (gen_eq) begin
                  gfound_r <= 1'b1;
                end
              end
              M_PURGE: begin
                if (keep_purge) begin
                  wp_r <= wp_r + CW'(1);
                  if (cand1 && beat1) begin
                    b1f_r <= 1'b1;
                    b1i_r <= wp_r[AW-1:0];
                    b1v_r <= t_e;
                    b1s_r <= e.seq;
                    b1e_r <= e;
                  end
                  if (cand2 && beat2) begin
                    b2f_r <= 1'b1;
                    b2i_r <= wp_r[AW-1:0];
                    b2d_r <= d_e;
                    b2s_r <= e.seq;
                    b2e_r <= e;
                  end
                end
              end
              default: begin
                if (keep_rm) begin
                  wp_r <= wp_r + CW'(1);
                end
              end
            endcase
          end else if (!ram_re) begin
            // scan finished: decide what follows
            case (mode_r)
              M_FIND: begin
                case (act_r)
                  fpq_pkg::ACT_PUSH: begin
                    if ((item_r.key != '0) && kfound_r) begin
                      if (rep) begin
                        wr_addr_r <= kidx_r;
                        state_r   <= S_WRITE;
                      end else begin
                        ov_r    <= 1'b1;
                        osucc_r <= 1'b0;
                        oent_r  <= '0;
                        state_r <= S_IDLE;
                      end
                    end else if (cnt_r == CW'(QUEUE_DEPTH)) begin
                      // evict first older generation, else the oldest
                      rm_r   <= ofound_r ? oidx_r : '0;
                      rp_r   <= ofound_r ? CW'(oidx_r) : '0;
                      wp_r   <= ofound_r ? CW'(oidx_r) : '0;
                      mode_r <= M_REMOVE;
                    end else begin
                      wr_addr_r <= cnt_r[AW-1:0];
                      cnt_r     <= cnt_r + CW'(1);
                      state_r   <= S_WRITE;
                    end
                  end
                  fpq_pkg::ACT_TAKE_NEWEST: begin
                    ov_r    <= 1'b1;
                    osucc_r <= any_r;
                    oent_r  <= any_r ? last_r : '0;
                    cnt_r   <= '0;
                    state_r <= S_IDLE;
                  end
                  fpq_pkg::ACT_HAS_GEN: begin
                    ov_r    <= 1'b1;
                    osucc_r <= gfound_r;
                    oent_r  <= '0;
                    state_r <= S_IDLE;
                  end
                  default: begin
                    ov_r    <= 1'b1;
                    osucc_r <= kfound_r && (item_r.key != '0);
                    oent_r  <= '0;
                    state_r <= S_IDLE;
                  end
                endcase
              end
              M_PURGE: begin
                cnt_r <= wp_r;
                if (b1f_r || b2f_r) begin
                  sel_r  <= b1f_r ? b1e_r : b2e_r;
                  rm_r   <= b1f_r ? b1i_r : b2i_r;
                  rp_r   <= CW'(b1f_r ? b1i_r : b2i_r);
                  wp_r   <= CW'(b1f_r ? b1i_r : b2i_r);
                  end_r  <= wp_r;
                  mode_r <= M_REMOVE;
                end else begin
                  ov_r    <= 1'b1;
                  osucc_r <= 1'b0;
                  oent_r  <= '0;
                  state_r <= S_IDLE;
                end
              end
              default: begin
                if (act_r == fpq_pkg::ACT_PUSH) begin
                  // room made: append the new frame
                  wr_addr_r <= wp_r[AW-1:0];
                  cnt_r     <= wp_r + CW'(1);
                  state_r   <= S_WRITE;
                end else begin
                  cnt_r   <= wp_r;
                  ov_r    <= 1'b1;
                  osucc_r <= 1'b1;
                  oent_r  <= sel_r;
                  state_r <= S_IDLE;
                end
              end
            endcase
          end
        end

        S_WRITE: begin
          ov_r    <= 1'b1;
          osucc_r <= 1'b1;
          oent_r  <= '0;
          state_r <= S_IDLE;
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_success    = osucc_r;
  assign out_handle     = oent_r.handle;
  assign out_time       = oent_r.tm;
  assign out_key        = oent_r.key;
  assign out_generation = oent_r.gen;
  assign out_sequence   = oent_r.seq;
  assign out_native     = oent_r.native;
  assign out_fallback   = oent_r.fallback;
  assign out_occupancy  = cnt_r;
  assign prdata         = {15'd0, mft_r};
  assign pready         = 1'b1;

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(QUEUE_DEPTH))
    else $error("entry count above depth");

  a_valid_after_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy || start))
    else $error("result without an item");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r != S_IDLE))
    else $error("table write while idle");
`endif

endmodule

// ----- design/fpq_ram.sv -----
// ----------------------------------------------------------------------------
// fpq_ram: generic single-clock RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module fpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the frame presentation queue
// Drives push, pop and query items through the command port, predicts each
// result with a table model kept in the bench, and programs min_frame_time
// over the APB port between phases.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH     = 8;
  localparam int MAX_CYCLE = 400000;

  // Register index of min_frame_time on the APB port.
  localparam logic [1:0] REG_MIN_FRAME_TIME = 2'd0;

  // Unused action code; the block must leave the table alone.
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;

  // One item on the command port.
  typedef struct {
    logic [2:0]         action;
    logic [31:0]        key;
    logic [31:0]        gen;
    logic signed [47:0] ftime;
    logic               native;
    logic               fallback;
    logic [31:0]        seq;
    logic [15:0]        handle;
    logic signed [47:0] target;
    logic [31:0]        duration;
  } cmd_t;

  // One result of the block.
  typedef struct packed {
    logic               success;
    logic [15:0]        handle;
    logic signed [47:0] ftime;
    logic [31:0]        key;
    logic [31:0]        gen;
    logic [31:0]        seq;
    logic               native;
    logic               fallback;
    logic [3:0]         occupancy;
  } reply_t;

  // --------------------------------------------------------------------------
  // Frame table model and reply scoreboard
  // --------------------------------------------------------------------------
  class frame_queue_board;
    fpq_pkg::entry_t slots[DEPTH];
    int           count;
    logic [16:0]  min_ft;
    reply_t       pending[$];
    int           errors;
    int           matched;
    int           pops;

    function new();
      count   = 0;
      min_ft  = fpq_pkg::MFT_RESET;
      errors  = 0;
      matched = 0;
      pops    = 0;
    endfunction

    function void drop_slot(int idx);
      for (int i = idx; i + 1 < count; i++) slots[i] = slots[i + 1];
      count--;
    endfunction

    function reply_t emit(int idx);
      reply_t r;
      r = '{default: '0};
      r.success  = 1'b1;
      r.handle   = slots[idx].handle;
      r.ftime    = slots[idx].tm;
      r.key      = slots[idx].key;
      r.gen      = slots[idx].gen;
      r.seq      = slots[idx].seq;
      r.native   = slots[idx].native;
      r.fallback = slots[idx].fallback;
      return r;
    endfunction

    function bit push_frame(cmd_t c);
      fpq_pkg::entry_t e;
      int     drop;
      bit     rep;
      e.key = c.key; e.gen = c.gen; e.tm = c.ftime; e.seq = c.seq;
      e.handle = c.handle; e.native = c.native; e.fallback = c.fallback;
      if (c.key != 0) begin
        for (int i = 0; i < count; i++) begin
          if (slots[i].key == c.key) begin
            if (c.native != slots[i].native) rep = c.native;
            else if (c.fallback != slots[i].fallback) rep = !c.fallback;
            else rep = 0;
            if (rep) slots[i] = e;
            return rep;
          end
        end
      end
      if (count >= DEPTH) begin
        drop = 0;
        for (int i = 0; i < count; i++) begin
          if (slots[i].gen < c.gen) begin
            drop = i;
            break;
          end
        end
        drop_slot(drop);
      end
      slots[count] = e;
      count++;
      return 1;
    endfunction

    // Purge stale frames, then pick the frame to show for the target time.
    function int pick_best(cmd_t c);
      longint fd, cutoff, limit, bval, d;
      int     w, best;
      logic [31:0] bseq;
      fd     = (c.duration > min_ft) ? longint'(c.duration) : longint'(min_ft);
      cutoff = longint'(c.target) - 2 * fd;
      limit  = longint'(c.target) + fd / 2;
      w = 0;
      for (int i = 0; i < count; i++) begin
        if (!(slots[i].gen < c.gen ||
              (slots[i].gen == c.gen && longint'(slots[i].tm) < cutoff))) begin
          slots[w] = slots[i];
          w++;
        end
      end
      count = w;
      best = -1; bval = 0; bseq = 0;
      for (int i = 0; i < count; i++) begin
        if (slots[i].gen != c.gen || longint'(slots[i].tm) > limit) continue;
        if (best < 0 || longint'(slots[i].tm) > bval ||
            (longint'(slots[i].tm) == bval && slots[i].seq > bseq)) begin
          best = i; bval = longint'(slots[i].tm); bseq = slots[i].seq;
        end
      end
      if (best < 0) begin
        for (int i = 0; i < count; i++) begin
          if (slots[i].gen != c.gen) continue;
          d = longint'(slots[i].tm) - longint'(c.target);
          if (d < 0 || d > fd) continue;
          if (best < 0 || d < bval || (d == bval && slots[i].seq > bseq)) begin
            best = i; bval = d; bseq = slots[i].seq;
          end
        end
      end
      return best;
    endfunction

    // Note an accepted item: advance the table and queue its reply.
    function void note_item(cmd_t c);
      reply_t r;
      int     b;
      r = '{default: '0};
      case (c.action)
        fpq_pkg::ACT_PUSH: r.success = push_frame(c);
        fpq_pkg::ACT_TAKE_NEWEST: begin
          if (count > 0) begin
            r = emit(count - 1);
            count = 0;
          end
        end
        fpq_pkg::ACT_TAKE_BEST: begin
          if (count > 0) begin
            b = pick_best(c);
            if (b >= 0) begin
              r = emit(b);
              drop_slot(b);
            end
          end
        end
        fpq_pkg::ACT_HAS_GEN: begin
          for (int i = 0; i < count; i++) if (slots[i].gen == c.gen) r.success = 1;
        end
        fpq_pkg::ACT_HAS_KEY: begin
          if (c.key != 0)
            for (int i = 0; i < count; i++) if (slots[i].key == c.key) r.success = 1;
        end
        fpq_pkg::ACT_FLUSH: begin
          count = 0;
          r.success = 1;
        end
        default: ;
      endcase
      if (r.success && (c.action == fpq_pkg::ACT_TAKE_NEWEST ||
                        c.action == fpq_pkg::ACT_TAKE_BEST)) pops++;
      r.occupancy = 4'(count);
      pending.insert(pending.size(), r);
    endfunction

    // Compare one reply with the oldest outstanding one.
    function void check_reply(reply_t a);
      reply_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected reply, success %0d occupancy %0d",
                 $time, a.success, a.occupancy);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (x !== a) begin
        errors++;
        $display("%0t: mismatch expected s=%0d h=%h t=%0d k=%h g=%h q=%h n=%0d f=%0d o=%0d",
                 $time, x.success, x.handle, x.ftime, x.key, x.gen, x.seq,
                 x.native, x.fallback, x.occupancy);
        $display("%0t:          actual   s=%0d h=%h t=%0d k=%h g=%h q=%h n=%0d f=%0d o=%0d",
                 $time, a.success, a.handle, a.ftime, a.key, a.gen, a.seq,
                 a.native, a.fallback, a.occupancy);
      end else begin
        matched++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #2 clk = ~clk;

  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_action = '0;
  logic [31:0]        in_frame_key = '0;
  logic [31:0]        in_generation = '0;
  logic signed [47:0] in_frame_time = '0;
  logic               in_native_buffer = 1'b0;
  logic               in_cpu_fallback = 1'b0;
  logic [31:0]        in_sequence_req = '0;
  logic [15:0]        in_handle = '0;
  logic signed [47:0] in_target_time = '0;
  logic [31:0]        in_frame_duration = '0;
  logic               out_valid;
  logic               out_success;
  logic [15:0]        out_handle;
  logic signed [47:0] out_time;
  logic [31:0]        out_key;
  logic [31:0]        out_generation;
  logic [31:0]        out_sequence;
  logic               out_native;
  logic               out_fallback;
  logic [3:0]         out_occupancy;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  frame_presentation_queue_core #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

  frame_queue_board board = new();
  int  cycles = 0;
  bit  no_gaps = 0;
  int  items = 0;

  // Sample replies at the edge that ends the strobe cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      reply_t a;
      a.success = out_success; a.handle = out_handle; a.ftime = out_time;
      a.key = out_key; a.gen = out_generation; a.seq = out_sequence;
      a.native = out_native; a.fallback = out_fallback; a.occupancy = out_occupancy;
      board.check_reply(a);
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLE) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Hold start until the block takes the item; note it in the model on accept.
  // Start stays high into the next item unless idle cycles come first.
  task automatic send_item(cmd_t c);
    if (!no_gaps && ($urandom_range(99) < 32)) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 32);
    end
    start             <= 1'b1;
    in_action         <= c.action;
    in_frame_key      <= c.key;
    in_generation     <= c.gen;
    in_frame_time     <= c.ftime;
    in_native_buffer  <= c.native;
    in_cpu_fallback   <= c.fallback;
    in_sequence_req   <= c.seq;
    in_handle         <= c.handle;
    in_target_time    <= c.target;
    in_frame_duration <= c.duration;
    do @(posedge clk); while (busy);
    board.note_item(c);
    items++;
  endtask

  // Drop start, drain the reply queue, then let the sequencer settle.
  task automatic wait_idle();
    start <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
  endtask

  task automatic write_min_ft(logic [16:0] v);
    wait_idle();
    psel <= 1'b1; pwrite <= 1'b1; paddr <= REG_MIN_FRAME_TIME; pwdata <= {15'd0, v};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    board.min_ft = v;
  endtask

  function automatic cmd_t blank(logic [2:0] act);
    cmd_t c;
    c = '{default: '0};
    c.action = act;
    return c;
  endfunction

  function automatic cmd_t push_of(logic [31:0] key, logic [31:0] gen,
                                   longint t, logic nat, logic fb, logic [31:0] seq);
    cmd_t c;
    c = blank(fpq_pkg::ACT_PUSH);
    c.key = key; c.gen = gen; c.ftime = 48'(t); c.native = nat; c.fallback = fb;
    c.seq = seq; c.handle = 16'($urandom);
    return c;
  endfunction

  function automatic cmd_t best_of(logic [31:0] gen, longint tgt, logic [31:0] dur);
    cmd_t c;
    c = blank(fpq_pkg::ACT_TAKE_BEST);
    c.gen = gen; c.target = 48'(tgt); c.duration = dur;
    return c;
  endfunction

  // Random item: mostly a realistic stream of a few generations and keys near
  // a moving clock, with some fully random noise.
  function automatic cmd_t rand_item(longint now, logic [31:0] gen_base);
    cmd_t c;
    int   pick;
    c = '{default: '0};
    c.action   = 3'($urandom_range(5));
    c.key      = ($urandom_range(3) == 0) ? 32'd0 : $urandom_range(12);
    c.gen      = gen_base + $urandom_range(2);
    c.ftime    = 48'(now + longint'($urandom_range(3000)) - 1500);
    c.native   = 1'($urandom_range(1));
    c.fallback = 1'($urandom_range(1));
    c.seq      = $urandom_range(6);
    c.handle   = 16'($urandom);
    c.target   = 48'(now + longint'($urandom_range(2000)) - 1000);
    c.duration = $urandom_range(900);
    pick = $urandom_range(99);
    if (pick < 45) c.action = fpq_pkg::ACT_PUSH;
    else if (pick < 70) c.action = fpq_pkg::ACT_TAKE_BEST;
    else if (pick < 90) begin
      c.key = $urandom; c.gen = $urandom;
      c.ftime = 48'({$urandom, $urandom}); c.target = 48'({$urandom, $urandom});
      c.seq = $urandom; c.duration = $urandom;
      c.action = 3'($urandom_range(7));
    end
    return c;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    longint      now;
    logic [31:0] gb;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty pops, key zero query, unused code.
    send_item(blank(fpq_pkg::ACT_TAKE_NEWEST));
    send_item(best_of(0, 0, 0));
    send_item(blank(fpq_pkg::ACT_HAS_KEY));
    send_item(blank(ACT_UNUSED_6));
    // Duplicate key: native wins, then non-fallback wins, equal flags fail.
    send_item(push_of(7, 1, 1000, 0, 1, 1));
    send_item(push_of(7, 1, 1100, 1, 1, 2));
    send_item(push_of(7, 1, 1200, 1, 0, 3));
    send_item(push_of(7, 1, 1300, 1, 0, 4));
    send_item(push_of(7, 1, 1300, 0, 0, 5));
    // Extreme times and fields; fill past depth to force evictions.
    send_item(push_of(32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'sh7FFF_FFFF_FFFF, 1, 1, '1));
    send_item(push_of(0, 0, -48'sh8000_0000_0000, 0, 0, 0));
    for (int i = 0; i < 8; i++) send_item(push_of(0, 2, 2000 + 100 * i, i[0], i[1], i));
    begin
      cmd_t q;
      q = blank(fpq_pkg::ACT_HAS_GEN); q.gen = 2;
      send_item(q);
      q = blank(fpq_pkg::ACT_HAS_KEY); q.key = 32'hFFFF_FFFF;
      send_item(q);
    end
    // Best-frame pops with ties on time, then a future frame only, then a
    // newest-frame pop.
    send_item(push_of(0, 2, 2200, 0, 0, 9));
    send_item(best_of(2, 2200, 0));
    send_item(best_of(2, 2600, 32'hFFFF_FFFF));
    send_item(best_of(2, 1500, 400));
    send_item(blank(fpq_pkg::ACT_TAKE_NEWEST));
    send_item(blank(fpq_pkg::ACT_FLUSH));

    // Random phases across register values, extremes included.
    now = 0;
    gb  = 5;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: write_min_ft(17'd1);
        1: write_min_ft(17'd90000);
        2: write_min_ft(17'h1FFFF);
        3: write_min_ft(17'd0);
        4: write_min_ft(17'd375);
        default: write_min_ft(17'd200);
      endcase
      no_gaps = (ph == 2);
      for (int n = 0; n < 225; n++) begin
        now += $urandom_range(400);
        if ($urandom_range(60) == 0) gb += 1;
        send_item(rand_item(now, gb));
      end
      // Hold the stream until every reply is back.
      if (ph == 3) wait_idle();
    end

    wait_idle();
    $display("Covered %0d items, %0d frames popped, %0d replies matched, six min_frame_time values.",
             items, board.pops, board.matched);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
